// ----- sv/bps_pkg.sv -----
// Shared types and constants for the beacon page selector.
package bps_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int MAX_PAGE    = 16;

    localparam int SLOT_W   = 6;
    localparam int CNT_W    = 7;
    localparam int ADDR_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int PICK_AW  = (MAX_PAGE > 1) ? $clog2(MAX_PAGE) : 1;
    localparam int PICK_CW  = $clog2(MAX_PAGE + 1);
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic OP_MARK = 1'b0;
    localparam logic OP_EMIT = 1'b1;

    localparam logic [PADDR_W-1:0] REG_MOBILE_NODE = 3'd0;

    typedef struct packed {
        logic              opcode;
        logic [SLOT_W-1:0] slot_index;
        logic [CNT_W-1:0]  table_count;
        logic              full_page;
    } bps_in_t;

    typedef struct packed {
        logic [SLOT_W-1:0] entry_index;
        logic              from_dirty;
        logic              page_empty;
        logic              last_of_page;
        logic [CNT_W-1:0]  dirty_total;
    } bps_out_t;

    typedef struct packed {
        logic [SLOT_W-1:0] idx;
        logic              from_dirty;
    } bps_pick_t;

    typedef struct packed {
        logic               vld;
        logic [PICK_AW-1:0] slot;
        bps_pick_t          pick;
    } bps_push_t;

    typedef struct packed {
        logic               start;
        logic [PICK_CW-1:0] npick;
        logic [CNT_W-1:0]   total;
    } bps_page_t;

    typedef struct packed {
        logic              vld;
        logic [SLOT_W-1:0] idx;
    } bps_clear_t;

endpackage

// ----- sv/bps_page_buf.sv -----
// Page buffer: collects picked slots and drains them as result beats.
module bps_page_buf (
    input  logic                clk,
    input  logic                rst_n,
    input  bps_pkg::bps_push_t  push,
    input  bps_pkg::bps_page_t  page,
    output logic                done,
    output bps_pkg::bps_clear_t clear,
    output logic                result_valid,
    input  logic                result_stall,
    output bps_pkg::bps_out_t   result
);

    bps_pkg::bps_pick_t pick_mem [bps_pkg::MAX_PAGE];

    logic                        active_reg, active_next;
    logic [bps_pkg::PICK_CW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [bps_pkg::PICK_CW-1:0] n_reg;
    logic [bps_pkg::CNT_W-1:0]   total_reg;
    logic                        out_vld_reg, out_vld_next;
    bps_pkg::bps_out_t           out_reg;
    bps_pkg::bps_pick_t          pick_rd_reg;

    logic               load;
    logic               is_last;
    logic               is_empty;
    bps_pkg::bps_pick_t cur_pick;

    always_ff @(posedge clk)
    begin
        if (push.vld)
        begin
            pick_mem[push.slot] <= push.pick;
        end
        pick_rd_reg <= pick_mem[rd_ptr_next[bps_pkg::PICK_AW-1:0]];
    end

    always_comb
    begin
        load     = active_reg && (!out_vld_reg || !result_stall);
        is_empty = (n_reg == '0);
        is_last  = is_empty || ((rd_ptr_reg + 1'b1) == n_reg);
        cur_pick = pick_rd_reg;

        active_next = active_reg;
        rd_ptr_next = rd_ptr_reg;
        if (page.start)
        begin
            active_next = 1'b1;
            rd_ptr_next = '0;
        end
        else if (load)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
            if (is_last)
            begin
                active_next = 1'b0;
            end
        end

        if (load)
        begin
            out_vld_next = 1'b1;
        end
        else if (result_stall)
        begin
            out_vld_next = out_vld_reg;
        end
        else
        begin
            out_vld_next = 1'b0;
        end

        done      = load && is_last;
        clear.vld = load && !is_empty && cur_pick.from_dirty;
        clear.idx = cur_pick.idx;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            rd_ptr_reg  <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            active_reg  <= active_next;
            rd_ptr_reg  <= rd_ptr_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (page.start)
        begin
            n_reg     <= page.npick;
            total_reg <= page.total;
        end
        if (load)
        begin
            out_reg.dirty_total  <= total_reg;
            out_reg.last_of_page <= is_last;
            out_reg.page_empty   <= is_empty;
            if (is_empty)
            begin
                out_reg.entry_index <= '0;
                out_reg.from_dirty  <= 1'b0;
            end
            else
            begin
                out_reg.entry_index <= cur_pick.idx;
                out_reg.from_dirty  <= cur_pick.from_dirty;
            end
        end
    end

    assign result_valid = out_vld_reg;
    assign result       = out_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        page.start |-> !active_reg)
        else $error("page start while draining");

    a_push_idle: assert property (@(posedge clk) disable iff (!rst_n)
        push.vld |-> !active_reg)
        else $error("pick pushed while draining");

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (rd_ptr_reg < n_reg) || (n_reg == '0))
        else $error("drain pointer past page end");

    a_done_drops: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !active_reg && out_vld_reg)
        else $error("drain did not finish on last beat");

endmodule

// ----- sv/beacon_page_selector.sv -----
// Top level of the beacon page selector: dirty-bit memory, scan sequencer, APB register.
// Mark beat: sets the dirty bit of the slot, no result. Emit beat: dirty scan, then for a
// full page with room left a cursor reduction and a rotation scan, then the page is opened
// and drained at one result beat per cycle while result_stall is low; the scans are skipped
// in mobile node mode. One item at a time: item_stall is high outside idle. After reset
// the dirty memory is swept clear with item_stall high.
module beacon_page_selector (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    output logic                         item_stall,
    input  bps_pkg::bps_in_t             item,
    output logic                         result_valid,
    input  logic                         result_stall,
    output bps_pkg::bps_out_t            result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bps_pkg::PADDR_W-1:0]  paddr,
    input  logic [bps_pkg::PDATA_W-1:0]  pwdata,
    output logic [bps_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);

    typedef enum logic [5:0] {
        S_INIT  = 6'b000001,
        S_IDLE  = 6'b000010,
        S_SCAN  = 6'b000100,
        S_MOD   = 6'b001000,
        S_ROT   = 6'b010000,
        S_DRAIN = 6'b100000
    } state_t;

    logic dirty_mem [bps_pkg::TABLE_DEPTH];

    state_t                      state_reg, state_next;
    logic [bps_pkg::ADDR_W-1:0]  init_ptr_reg, init_ptr_next;
    logic                        mobile_reg;
    logic [bps_pkg::ADDR_W-1:0]  cursor_reg, cursor_next;
    logic [bps_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic                        full_reg, full_next;
    logic [bps_pkg::ADDR_W-1:0]  iss_ptr_reg, iss_ptr_next;
    logic [bps_pkg::CNT_W-1:0]   iss_left_reg, iss_left_next;
    logic [bps_pkg::ADDR_W-1:0]  base_reg, base_next;
    logic                        rd_vld_reg, rd_vld_next;
    logic [bps_pkg::ADDR_W-1:0]  rd_tag_reg;
    logic                        rd_data_reg;
    logic [bps_pkg::CNT_W-1:0]   total_reg, total_next;
    logic [bps_pkg::PICK_CW-1:0] npick_reg, npick_next;
    logic                        start_reg, start_next;

    logic                        accept;
    logic                        cfg_wr;
    logic [bps_pkg::CNT_W-1:0]   cnt_sat;
    logic                        issue;
    logic                        room;
    logic [bps_pkg::CNT_W-1:0]   iss_inc;
    logic [bps_pkg::CNT_W-1:0]   tag_inc;
    logic                        mem_we;
    logic [bps_pkg::ADDR_W-1:0]  mem_waddr;
    logic                        mem_wdata;
    logic                        done;
    bps_pkg::bps_push_t          push;
    bps_pkg::bps_page_t          page;
    bps_pkg::bps_clear_t         clear;

    assign accept     = item_valid && !item_stall;
    assign item_stall = (state_reg != S_IDLE);
    assign cfg_wr     = psel && penable && pwrite && pready;
    assign pready     = 1'b1;
    assign prdata     = (paddr == bps_pkg::REG_MOBILE_NODE)
                        ? {{(bps_pkg::PDATA_W-1){1'b0}}, mobile_reg} : '0;

    always_comb
    begin
        cnt_sat = (item.table_count > bps_pkg::CNT_W'(bps_pkg::TABLE_DEPTH))
                  ? bps_pkg::CNT_W'(bps_pkg::TABLE_DEPTH) : item.table_count;
        room    = (npick_reg < bps_pkg::PICK_CW'(bps_pkg::MAX_PAGE));
        iss_inc = bps_pkg::CNT_W'(iss_ptr_reg) + 1'b1;
        tag_inc = bps_pkg::CNT_W'(rd_tag_reg) + 1'b1;

        state_next    = state_reg;
        init_ptr_next = init_ptr_reg;
        cursor_next   = cursor_reg;
        cnt_next      = cnt_reg;
        full_next     = full_reg;
        iss_ptr_next  = iss_ptr_reg;
        iss_left_next = iss_left_reg;
        base_next     = base_reg;
        total_next    = total_reg;
        npick_next    = npick_reg;
        start_next    = 1'b0;
        issue         = 1'b0;

        mem_we    = 1'b0;
        mem_waddr = bps_pkg::ADDR_W'(item.slot_index);
        mem_wdata = 1'b0;

        push.vld             = 1'b0;
        push.slot            = npick_reg[bps_pkg::PICK_AW-1:0];
        push.pick.idx        = bps_pkg::SLOT_W'(rd_tag_reg);
        push.pick.from_dirty = 1'b0;

        unique case (state_reg)
            S_INIT:
            begin
                mem_we        = 1'b1;
                mem_waddr     = init_ptr_reg;
                init_ptr_next = init_ptr_reg + 1'b1;
                if (init_ptr_reg == bps_pkg::ADDR_W'(bps_pkg::TABLE_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept && item.opcode == bps_pkg::OP_MARK)
                begin
                    mem_we    = ({1'b0, item.slot_index} <
                                 (bps_pkg::SLOT_W+1)'(bps_pkg::TABLE_DEPTH));
                    mem_wdata = 1'b1;
                end
                else if (accept)
                begin
                    cnt_next      = cnt_sat;
                    full_next     = item.full_page;
                    total_next    = '0;
                    npick_next    = '0;
                    iss_ptr_next  = '0;
                    iss_left_next = cnt_sat;
                    if (mobile_reg)
                    begin
                        start_next = 1'b1;
                        state_next = S_DRAIN;
                    end
                    else if (cnt_sat == '0)
                    begin
                        cursor_next = '0;
                        start_next  = 1'b1;
                        state_next  = S_DRAIN;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                issue = (iss_left_reg != '0);
                if (rd_vld_reg && rd_data_reg)
                begin
                    total_next = total_reg + 1'b1;
                    if (room)
                    begin
                        push.vld             = 1'b1;
                        push.pick.from_dirty = 1'b1;
                        npick_next           = npick_reg + 1'b1;
                    end
                end
                if (!issue && !rd_vld_reg)
                begin
                    if (full_reg && room)
                    begin
                        base_next  = cursor_reg;
                        state_next = S_MOD;
                    end
                    else
                    begin
                        start_next = 1'b1;
                        state_next = S_DRAIN;
                    end
                end
            end
            S_MOD:
            begin
                if (bps_pkg::CNT_W'(base_reg) >= cnt_reg)
                begin
                    base_next = bps_pkg::ADDR_W'(bps_pkg::CNT_W'(base_reg) - cnt_reg);
                end
                else
                begin
                    iss_ptr_next  = base_reg;
                    iss_left_next = cnt_reg;
                    state_next    = S_ROT;
                end
            end
            S_ROT:
            begin
                issue = (iss_left_reg != '0) && room;
                if (rd_vld_reg && room)
                begin
                    cursor_next = (tag_inc == cnt_reg) ? '0 : bps_pkg::ADDR_W'(tag_inc);
                    if (!rd_data_reg)
                    begin
                        push.vld   = 1'b1;
                        npick_next = npick_reg + 1'b1;
                    end
                end
                if (!room || (iss_left_reg == '0 && !rd_vld_reg))
                begin
                    start_next = 1'b1;
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                mem_we    = clear.vld;
                mem_waddr = bps_pkg::ADDR_W'(clear.idx);
                mem_wdata = 1'b0;
                if (done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (issue)
        begin
            iss_left_next = iss_left_reg - 1'b1;
            iss_ptr_next  = (iss_inc == cnt_reg) ? '0 : bps_pkg::ADDR_W'(iss_inc);
        end
        rd_vld_next = issue;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            dirty_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= dirty_mem[iss_ptr_reg];
        rd_tag_reg  <= iss_ptr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_INIT;
            init_ptr_reg <= '0;
            mobile_reg   <= 1'b0;
            cursor_reg   <= '0;
            iss_left_reg <= '0;
            rd_vld_reg   <= 1'b0;
            npick_reg    <= '0;
            start_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            init_ptr_reg <= init_ptr_next;
            cursor_reg   <= cursor_next;
            iss_left_reg <= iss_left_next;
            rd_vld_reg   <= rd_vld_next;
            npick_reg    <= npick_next;
            start_reg    <= start_next;
            if (cfg_wr && paddr == bps_pkg::REG_MOBILE_NODE)
            begin
                mobile_reg <= pwdata[0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg     <= cnt_next;
        full_reg    <= full_next;
        iss_ptr_reg <= iss_ptr_next;
        base_reg    <= base_next;
        total_reg   <= total_next;
    end

    always_comb
    begin
        page.start = start_reg;
        page.npick = npick_reg;
        page.total = total_reg;
    end

    bps_page_buf u_page_buf (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .page         (page),
        .done         (done),
        .clear        (clear),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    a_clear_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        clear.vld |-> state_reg == S_DRAIN)
        else $error("dirty clear outside drain");

    a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |-> (state_reg == S_SCAN) || (state_reg == S_ROT)
                       || (state_reg == S_DRAIN))
        else $error("read data pending in wrong state");

    a_npick_bound: assert property (@(posedge clk) disable iff (!rst_n)
        npick_reg <= bps_pkg::PICK_CW'(bps_pkg::MAX_PAGE))
        else $error("page overfilled");

    a_start_enters_drain: assert property (@(posedge clk) disable iff (!rst_n)
        start_reg |-> state_reg == S_DRAIN && $past(state_reg) != S_DRAIN)
        else $error("page start without drain entry");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the beacon page selector: directed, mobile and random traffic.
module tb;

    localparam int WATCHDOG_CYCLES = 4000;
    localparam int QUIET_CYCLES    = 16;
    localparam int DRAIN_CYCLES    = 300;

    logic                         clk          = 1'b0;
    logic                         rst_n        = 1'b0;
    logic                         item_valid   = 1'b0;
    logic                         item_stall;
    bps_pkg::bps_in_t             item_beat    = '0;
    logic                         result_valid;
    logic                         result_stall = 1'b0;
    bps_pkg::bps_out_t            result_beat;
    logic                         psel         = 1'b0;
    logic                         penable      = 1'b0;
    logic                         pwrite       = 1'b0;
    logic [bps_pkg::PADDR_W-1:0]  paddr        = '0;
    logic [bps_pkg::PDATA_W-1:0]  pwdata       = '0;
    logic [bps_pkg::PDATA_W-1:0]  prdata;
    logic                         pready;

    bit [bps_pkg::TABLE_DEPTH-1:0] shadow_dirty  = '0;
    int                            shadow_cursor = 0;
    logic                          shadow_mobile = 1'b0;
    bps_pkg::bps_out_t             page_entries_due[$];
    int                            mismatches    = 0;
    int                            idle_cycles   = 0;
    bit                            calm_traffic  = 1'b0;

    beacon_page_selector u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item_beat),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result_beat),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #6 clk = ~clk;

    function automatic int draw_wait();
        if (calm_traffic || $urandom_range(3) == 0)
            return 0;
        return $urandom_range(13);
    endfunction

    function automatic void predict_beacon_page(input bps_pkg::bps_in_t beat);
        int                cnt;
        int                dn;
        int                total;
        int                base;
        int                steps;
        int                ri;
        int                picks[$];
        bps_pkg::bps_out_t entry;
        dn    = 0;
        total = 0;
        if (beat.opcode == bps_pkg::OP_MARK)
        begin
            shadow_dirty[beat.slot_index] = 1'b1;
            return;
        end
        cnt = (beat.table_count > bps_pkg::TABLE_DEPTH) ? bps_pkg::TABLE_DEPTH
                                                        : int'(beat.table_count);
        if (!shadow_mobile)
        begin
            if (cnt == 0)
                shadow_cursor = 0;
            for (int i = 0; i < cnt; i++)
                if (shadow_dirty[i])
                    total++;
            for (int i = 0; i < cnt && picks.size() < bps_pkg::MAX_PAGE; i++)
            begin
                if (shadow_dirty[i])
                begin
                    picks.push_back(i);
                    dn++;
                end
            end
            if (beat.full_page && cnt > 0 && picks.size() < bps_pkg::MAX_PAGE)
            begin
                base  = shadow_cursor % cnt;
                steps = 0;
                while (picks.size() < bps_pkg::MAX_PAGE && steps < cnt)
                begin
                    ri = (base + steps) % cnt;
                    if (!shadow_dirty[ri])
                        picks.push_back(ri);
                    steps++;
                end
                shadow_cursor = (base + steps) % cnt;
            end
            for (int i = 0; i < dn; i++)
                shadow_dirty[picks[i]] = 1'b0;
        end
        if (picks.size() == 0)
        begin
            entry              = '0;
            entry.page_empty   = 1'b1;
            entry.last_of_page = 1'b1;
            entry.dirty_total  = total[bps_pkg::CNT_W-1:0];
            page_entries_due.push_back(entry);
            return;
        end
        for (int i = 0; i < picks.size(); i++)
        begin
            entry              = '0;
            entry.entry_index  = picks[i][bps_pkg::SLOT_W-1:0];
            entry.from_dirty   = (i < dn);
            entry.last_of_page = (i == picks.size() - 1);
            entry.dirty_total  = total[bps_pkg::CNT_W-1:0];
            page_entries_due.push_back(entry);
        end
    endfunction

    function automatic bps_pkg::bps_in_t make_beat(input logic op, input int slot,
                                                   input int cnt, input logic full);
        bps_pkg::bps_in_t beat;
        beat.opcode      = op;
        beat.slot_index  = slot[bps_pkg::SLOT_W-1:0];
        beat.table_count = cnt[bps_pkg::CNT_W-1:0];
        beat.full_page   = full;
        if (op == bps_pkg::OP_MARK)
        begin
            beat.table_count = bps_pkg::CNT_W'($urandom_range(127));
            beat.full_page   = 1'($urandom_range(1));
        end
        else
            beat.slot_index = bps_pkg::SLOT_W'($urandom_range(63));
        return beat;
    endfunction

    function automatic void check_field(input string field, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
            mismatches++;
        end
    endfunction

    task automatic send_beat(input bps_pkg::bps_in_t beat);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_beat  <= beat;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall !== 1'b0)
            @(posedge clk);
        predict_beacon_page(beat);
    endtask

    task automatic settle_block(input int cycles);
        item_valid <= 1'b0;
        while (page_entries_due.size() != 0)
            @(posedge clk);
        repeat (cycles) @(posedge clk);
    endtask

    task automatic config_write(input logic value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= bps_pkg::REG_MOBILE_NODE;
        pwdata  <= {{(bps_pkg::PDATA_W-1){1'b0}}, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        shadow_mobile = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[0] !== shadow_mobile)
        begin
            $display("%0t: mobile_node readback expected %0d actual %0d",
                     $time, shadow_mobile, prdata[0]);
            mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic test_basic_pages();
        config_write(1'b0);
        send_beat(make_beat(bps_pkg::OP_EMIT, 0, 0, 1'b1));
        send_beat(make_beat(bps_pkg::OP_MARK, 0, 0, 1'b0));
        send_beat(make_beat(bps_pkg::OP_MARK, 63, 0, 1'b0));
        send_beat(make_beat(bps_pkg::OP_MARK, 5, 0, 1'b0));
        send_beat(make_beat(bps_pkg::OP_EMIT, 0, 64, 1'b0));
        send_beat(make_beat(bps_pkg::OP_EMIT, 0, 0, 1'b0));
        send_beat(make_beat(bps_pkg::OP_MARK, 63, 0, 1'b0));
        send_beat(make_beat(bps_pkg::OP_EMIT, 0, 10, 1'b1));
        send_beat(make_beat(bps_pkg::OP_EMIT, 0, 127, 1'b1));
        send_beat(make_beat(bps_pkg::OP_EMIT, 0, 7, 1'b1));
        send_beat(make_beat(bps_pkg::OP_EMIT, 0, 1, 1'b1));
    endtask

    task automatic test_page_capacity();
        for (int s = 40; s < 57; s++)
            send_beat(make_beat(bps_pkg::OP_MARK, s, 0, 1'b0));
        send_beat(make_beat(bps_pkg::OP_EMIT, 0, 64, 1'b1));
        send_beat(make_beat(bps_pkg::OP_EMIT, 0, 65, 1'b0));
    endtask

    task automatic test_mobile_node();
        settle_block(QUIET_CYCLES);
        config_write(1'b1);
        send_beat(make_beat(bps_pkg::OP_MARK, 3, 0, 1'b0));
        send_beat(make_beat(bps_pkg::OP_EMIT, 0, 64, 1'b1));
        send_beat(make_beat(bps_pkg::OP_EMIT, 0, 0, 1'b1));
        settle_block(QUIET_CYCLES);
        config_write(1'b0);
        send_beat(make_beat(bps_pkg::OP_EMIT, 0, 64, 1'b1));
    endtask

    task automatic random_phase(input int count);
        int   pick;
        int   cnt;
        logic op;
        for (int n = 0; n < count; n++)
        begin
            op   = ($urandom_range(99) < 55) ? bps_pkg::OP_MARK : bps_pkg::OP_EMIT;
            pick = $urandom_range(9);
            if (pick == 0)
                cnt = $urandom_range(127, 65);
            else if (pick == 1)
                cnt = $urandom_range(3);
            else
                cnt = $urandom_range(64);
            send_beat(make_beat(op, $urandom_range(63), cnt, 1'($urandom_range(1))));
        end
    endtask

    task automatic test_random_traffic();
        random_phase(60);
        settle_block(0);
        random_phase(60);
        calm_traffic = 1'b1;
        random_phase(60);
        calm_traffic = 1'b0;
        settle_block(QUIET_CYCLES);
        config_write(1'b1);
        random_phase(30);
        settle_block(QUIET_CYCLES);
        config_write(1'b0);
        random_phase(140);
    endtask

    initial
    begin : result_sink
        int                hold;
        bps_pkg::bps_out_t want;
        forever
        begin
            hold = draw_wait();
            if (hold > 0)
            begin
                result_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                result_stall <= 1'b0;
            end
            @(posedge clk);
            while (result_valid !== 1'b1)
                @(posedge clk);
            if (page_entries_due.size() == 0)
            begin
                $display("%0t: unexpected result beat expected none actual %p", $time,
                         result_beat);
                mismatches++;
            end
            else
            begin
                want = page_entries_due.pop_front();
                check_field("entry_index", int'(want.entry_index),
                            int'(result_beat.entry_index));
                check_field("from_dirty", int'(want.from_dirty),
                            int'(result_beat.from_dirty));
                check_field("page_empty", int'(want.page_empty),
                            int'(result_beat.page_empty));
                check_field("last_of_page", int'(want.last_of_page),
                            int'(result_beat.last_of_page));
                check_field("dirty_total", int'(want.dirty_total),
                            int'(result_beat.dirty_total));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((item_valid && item_stall === 1'b0) || (result_valid === 1'b1 && !result_stall))
            idle_cycles <= 0;
        else if (idle_cycles + 1 >= WATCHDOG_CYCLES)
        begin
            $display("FAIL beacon_page_selector");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        test_basic_pages();
        test_page_capacity();
        test_mobile_node();
        test_random_traffic();
        settle_block(DRAIN_CYCLES);
        if (mismatches == 0)
            $display("PASS beacon_page_selector");
        else
            $display("FAIL beacon_page_selector");
        $finish;
    end

endmodule
